/* rtl/erf_pkg.sv */
// Shared types, record layout constants and CRC helper for the event record framer.
`default_nettype none

package erf_pkg;

    // Record layout in bytes.
    localparam int MAX_REC     = 67;
    localparam int HDR_LEN     = 13;
    localparam int CRC_LEN     = 4;
    localparam int PLEN_NEW    = 50;
    localparam int PLEN_CANCEL = 16;
    localparam int PLEN_FILL   = 45;
    localparam int REC_W       = MAX_REC * 8;

    // The CRC unit folds in this many bytes per cycle.
    localparam int CRC_BYTES     = 8;
    localparam int CRC_BUF_BYTES = ((MAX_REC - CRC_LEN + CRC_BYTES - 1) / CRC_BYTES) * CRC_BYTES;
    localparam int CRC_BUF_W     = CRC_BUF_BYTES * 8;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_NEW    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FILL   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANCEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL      = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [63:0]        sequence_req;
        logic [63:0]        timestamp;
        logic [63:0]        order_id;
        logic [63:0]        second_id;
        logic [31:0]        symbol_id;
        logic [31:0]        trader_id;
        logic               is_buy;
        logic signed [63:0] price_ticks;
        logic [31:0]        quantity;
        logic [31:0]        remaining_quantity;
        logic [7:0]         order_type;
    } event_t;

    typedef struct packed {
        logic [63:0] beat_data;
        logic [3:0]  beat_bytes;
        logic        beat_last;
    } beat_t;

    typedef struct packed {
        logic load;
        logic run;
        logic emit;
    } erf_cmd_t;

    typedef struct packed {
        logic beat_ok;
        logic beat_last;
    } erf_stat_t;

    // One byte of the reflected CRC-32, least significant bit first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/erf_ctrl.sv */
// Controller of the event record framer: item intake, CRC run and beat hand-off.
`default_nettype none

module erf_ctrl
    import erf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [KIND_W-1:0] in_kind,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire erf_stat_t         stat,
    output erf_cmd_t               cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        // A beat of kind three is taken and dropped without a record.
        cmd.load = in_valid && in_ready && (in_kind != KIND_NONE);
        cmd.run  = (state_reg == ST_BUSY);
        cmd.emit = (state_reg == ST_BUSY) && stat.beat_ok && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                    state_next = ST_BUSY;
            end
            ST_BUSY:
            begin
                if (cmd.emit && stat.beat_last)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_BUSY)
        else $error("record load did not start the busy phase");

    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUSY) && !(cmd.emit && stat.beat_last) |=> state_reg == ST_BUSY)
        else $error("left the busy phase before the last beat was handed off");

    a_emit_shows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("handed-off beat is not presented");

endmodule

`default_nettype wire

/* rtl/erf_datapath.sv */
// Datapath of the event record framer: record build, CRC unit and beat slicer.
`default_nettype none

module erf_datapath
    import erf_pkg::*;
#(
    parameter int BEAT_BYTES = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire event_t               in_data,
    input  wire erf_cmd_t             cmd,
    output erf_stat_t                 stat,
    output beat_t                     out_data
);

    localparam int POS_W = $clog2(MAX_REC + 2 * BEAT_BYTES + CRC_BYTES);
    localparam logic [POS_W-1:0] BB_POS    = POS_W'(BEAT_BYTES);
    localparam logic [POS_W-1:0] CRC_STEP  = POS_W'(CRC_BYTES);
    localparam logic [POS_W-1:0] CRC_BYTES_POS = POS_W'(CRC_LEN);

    logic [7:0] new_code_reg;
    logic [7:0] cancel_code_reg;
    logic [7:0] fill_code_reg;

    logic [REC_W-1:0]     emit_reg;
    logic [CRC_BUF_W-1:0] crc_buf_reg;
    logic [31:0]          crc_reg;
    logic [POS_W-1:0]     crc_pos_reg;
    logic                 crc_done_reg;
    logic [POS_W-1:0]     start_reg;
    logic [POS_W-1:0]     pre_len_reg;
    beat_t                out_reg;

    logic [REC_W-1:0] rec;
    logic [POS_W-1:0] pre_len_load;
    logic [31:0]      crc_next;
    logic             crc_last;
    logic [31:0]      crc_final;
    logic [POS_W-1:0] rec_len;
    logic [POS_W-1:0] rem_bytes;
    logic [POS_W-1:0] cnt;
    logic [POS_W-1:0] beat_end;
    logic [63:0]      lane_data;
    logic [7:0]       buy_byte;

    assign buy_byte = {7'd0, in_data.is_buy};

    // Record image with the CRC bytes left zero; they are merged in on the way out.
    always_comb
    begin
        rec          = '0;
        pre_len_load = '0;
        unique case (in_data.kind)
            KIND_NEW:
            begin
                rec = {32'(PLEN_NEW), in_data.sequence_req, new_code_reg,
                       in_data.timestamp, in_data.order_id, in_data.symbol_id,
                       in_data.trader_id, buy_byte, in_data.price_ticks,
                       in_data.quantity, in_data.remaining_quantity,
                       in_data.order_type, in_data.second_id, 32'd0};
                pre_len_load = POS_W'(HDR_LEN + PLEN_NEW);
            end
            KIND_CANCEL:
            begin
                rec = {32'(PLEN_CANCEL), in_data.sequence_req, cancel_code_reg,
                       in_data.timestamp, in_data.order_id, 304'd0};
                pre_len_load = POS_W'(HDR_LEN + PLEN_CANCEL);
            end
            KIND_FILL:
            begin
                rec = {32'(PLEN_FILL), in_data.sequence_req, fill_code_reg,
                       in_data.timestamp, in_data.order_id, in_data.second_id,
                       in_data.symbol_id, in_data.trader_id, in_data.quantity,
                       in_data.price_ticks, buy_byte, 72'd0};
                pre_len_load = POS_W'(HDR_LEN + PLEN_FILL);
            end
            default:
            begin
                rec          = '0;
                pre_len_load = '0;
            end
        endcase
    end

    // CRC unit: folds the next eight record bytes, stopping at the end of the body.
    always_comb
    begin
        crc_next = crc_reg;
        for (int b = 0; b < CRC_BYTES; b++)
        begin
            if ((crc_pos_reg + POS_W'(b)) < pre_len_reg)
                crc_next = crc32_byte(crc_next, crc_buf_reg[CRC_BUF_W-1-8*b -: 8]);
        end
    end

    assign crc_last  = (crc_pos_reg + CRC_STEP) >= pre_len_reg;
    assign crc_final = crc_reg ^ CRC_XOROUT;

    assign rec_len   = pre_len_reg + CRC_BYTES_POS;
    assign rem_bytes = rec_len - start_reg;
    assign cnt       = (rem_bytes < BB_POS) ? rem_bytes : BB_POS;
    assign beat_end  = start_reg + BB_POS;

    // A beat that holds no CRC byte can leave before the CRC is finished.
    assign stat.beat_ok   = crc_done_reg || (beat_end <= pre_len_reg);
    assign stat.beat_last = (rem_bytes <= BB_POS);

    for (genvar p = 0; p < 8; p++)
    begin : g_lane
        if (p < BEAT_BYTES)
        begin : g_used
            localparam int I = BEAT_BYTES - 1 - p;
            logic [POS_W-1:0] idx;
            logic [POS_W-1:0] crc_ofs;
            logic [7:0]       crc_byte;

            assign idx     = start_reg + POS_W'(I);
            assign crc_ofs = idx - pre_len_reg;

            always_comb
            begin
                crc_byte = 8'd0;
                if ((idx >= pre_len_reg) && (crc_ofs < CRC_BYTES_POS))
                begin
                    unique case (crc_ofs[1:0])
                        2'd0: crc_byte = crc_final[31:24];
                        2'd1: crc_byte = crc_final[23:16];
                        2'd2: crc_byte = crc_final[15:8];
                        2'd3: crc_byte = crc_final[7:0];
                    endcase
                end
            end

            assign lane_data[8*p +: 8] = emit_reg[REC_W-1-8*I -: 8] | crc_byte;
        end
        else
        begin : g_unused
            assign lane_data[8*p +: 8] = 8'd0;
        end
    end

    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_code_reg    <= 8'd0;
            cancel_code_reg <= 8'd1;
            fill_code_reg   <= 8'd2;
            crc_done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_NEW_ORDER: new_code_reg    <= cfg_data;
                    CFG_CANCEL:    cancel_code_reg <= cfg_data;
                    CFG_FILL:      fill_code_reg   <= cfg_data;
                    default:       ;
                endcase
            end
            if (cmd.load)
                crc_done_reg <= 1'b0;
            else if (cmd.run && !crc_done_reg && crc_last)
                crc_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            emit_reg    <= rec;
            crc_buf_reg <= rec[REC_W-1 -: CRC_BUF_W];
            crc_reg     <= CRC_INIT;
            crc_pos_reg <= '0;
            start_reg   <= '0;
            pre_len_reg <= pre_len_load;
        end
        else
        begin
            if (cmd.run && !crc_done_reg)
            begin
                crc_reg     <= crc_next;
                crc_pos_reg <= crc_pos_reg + CRC_STEP;
                crc_buf_reg <= crc_buf_reg << (8 * CRC_BYTES);
            end
            if (cmd.emit)
            begin
                emit_reg  <= emit_reg << (8 * BEAT_BYTES);
                start_reg <= beat_end;
            end
        end
        if (cmd.emit)
        begin
            out_reg.beat_data  <= lane_data;
            out_reg.beat_bytes <= cnt[3:0];
            out_reg.beat_last  <= stat.beat_last;
        end
    end

    a_crc_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        crc_done_reg && !cmd.load |=> crc_done_reg)
        else $error("CRC finished flag dropped within a record");

    a_last_after_crc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && stat.beat_last |-> crc_done_reg)
        else $error("last beat handed off before the CRC was complete");

endmodule

`default_nettype wire

/* rtl/event_record_framer_crc32.sv */
// Event record framer: turns one trading event into a length-prefixed record with CRC-32.
//
// Input channel (in_valid/in_ready/in_data) takes one event per beat. It is ready
// whenever no record is being built, even while the last output beat waits.
// Output channel (out_valid/out_ready/out_data) gives BEAT_BYTES record bytes per
// beat, first byte most significant, with a byte count and a last flag.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the three
// command bytes; it is always ready. Write it only while the block is idle.
// An event of kind three is taken and gives no record.
// Intake sets the busy state; the first beat then goes into the output register.
// One beat leaves per cycle while the receiver takes them, and the beat that holds
// the CRC waits for the CRC unit, which folds in eight bytes per cycle.
// A stalled receiver holds the output register and the record in place.
// Reset clears the control state and loads the default command bytes 0, 1 and 2.
`default_nettype none

module event_record_framer_crc32
    import erf_pkg::*;
#(
    parameter int BEAT_BYTES = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire event_t               in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output beat_t                     out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    erf_cmd_t  cmd;
    erf_stat_t stat;

    assign cfg_ready = 1'b1;

    erf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_kind   (in_data.kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    erf_datapath #(
        .BEAT_BYTES (BEAT_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* tb/sv/event_record_framer_crc32_test.sv */
// Self-checking testbench for the event record framer: random events in, framed beats checked.
module event_record_framer_crc32_test;
    timeunit 1ns;
    timeprecision 1ps;

    import erf_pkg::*;

    localparam int LANE_BYTES = 8;
    // Kind three is taken without a record, so wait this long before touching registers.
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_EVENTS = 62;
    localparam int REPORT_MAX = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Predicts the beats of each accepted event and checks the beats that come out.
    class record_checker;
        logic [7:0] new_order_code;
        logic [7:0] cancel_code;
        logic [7:0] fill_code;
        logic [7:0] rec_bytes [MAX_REC];
        int wr_pos;
        beat_t expected_beats[$];
        int failures;

        function new();
            new_order_code = 8'd0;
            cancel_code = 8'd1;
            fill_code = 8'd2;
            failures = 0;
        endfunction

        function void set_code(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_NEW_ORDER: new_order_code = val;
                CFG_CANCEL:    cancel_code = val;
                CFG_FILL:      fill_code = val;
                default:       ;
            endcase
        endfunction

        function void append(logic [63:0] val, int nbytes);
            for (int i = nbytes - 1; i >= 0; i--)
            begin
                rec_bytes[wr_pos] = val[8*i +: 8];
                wr_pos++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void frame_event(event_t ev);
            int plen;
            int total;
            int nbeats;
            int cnt;
            logic [7:0] cmd;
            logic [31:0] crc;
            beat_t b;
            if (ev.kind == KIND_NONE)
                return;
            wr_pos = HDR_LEN;
            append(ev.timestamp, 8);
            case (ev.kind)
                KIND_NEW:
                begin
                    plen = PLEN_NEW;
                    cmd = new_order_code;
                    append(ev.order_id, 8);
                    append(64'(ev.symbol_id), 4);
                    append(64'(ev.trader_id), 4);
                    append(64'(ev.is_buy), 1);
                    append(ev.price_ticks, 8);
                    append(64'(ev.quantity), 4);
                    append(64'(ev.remaining_quantity), 4);
                    append(64'(ev.order_type), 1);
                    append(ev.second_id, 8);
                end
                KIND_CANCEL:
                begin
                    plen = PLEN_CANCEL;
                    cmd = cancel_code;
                    append(ev.order_id, 8);
                end
                default:
                begin
                    plen = PLEN_FILL;
                    cmd = fill_code;
                    append(ev.order_id, 8);
                    append(ev.second_id, 8);
                    append(64'(ev.symbol_id), 4);
                    append(64'(ev.trader_id), 4);
                    append(64'(ev.quantity), 4);
                    append(ev.price_ticks, 8);
                    append(64'(ev.is_buy), 1);
                end
            endcase
            wr_pos = 0;
            append(64'(plen), 4);
            append(ev.sequence_req, 8);
            append(64'(cmd), 1);

            // Reflected CRC-32, folded one byte at a time, low bit first.
            crc = CRC_INIT;
            for (int i = 0; i < HDR_LEN + plen; i++)
            begin
                crc = crc ^ {24'd0, rec_bytes[i]};
                for (int k = 0; k < 8; k++)
                    crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
            crc = crc ^ CRC_XOROUT;
            wr_pos = HDR_LEN + plen;
            append(64'(crc), 4);

            total = wr_pos;
            nbeats = (total + LANE_BYTES - 1) / LANE_BYTES;
            for (int beat = 0; beat < nbeats; beat++)
            begin
                cnt = total - beat * LANE_BYTES;
                if (cnt > LANE_BYTES)
                    cnt = LANE_BYTES;
                b.beat_data = '0;
                for (int i = 0; i < LANE_BYTES; i++)
                    b.beat_data = {b.beat_data[55:0],
                                   (i < cnt) ? rec_bytes[beat * LANE_BYTES + i] : 8'h00};
                b.beat_bytes = 4'(cnt);
                b.beat_last = (beat == nbeats - 1);
                expected_beats.push_back(b);
            end
        endfunction

        function void check_beat(beat_t got);
            beat_t want;
            bit bad;
            if (expected_beats.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected beat: data %h bytes %0d last %0b",
                             got.beat_data, got.beat_bytes, got.beat_last);
                return;
            end
            want = expected_beats.pop_front();
            bad = 1'b0;
            if (got.beat_data !== want.beat_data)
                bad = 1'b1;
            if (got.beat_bytes !== want.beat_bytes)
                bad = 1'b1;
            if (got.beat_last !== want.beat_last)
                bad = 1'b1;
            if (bad)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("beat mismatch: expected data %h bytes %0d last %0b, got data %h bytes %0d last %0b",
                             want.beat_data, want.beat_bytes, want.beat_last,
                             got.beat_data, got.beat_bytes, got.beat_last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    event_t in_data;
    logic out_valid;
    logic out_ready;
    beat_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_data;

    record_checker ledger = new();

    event_record_framer_crc32 #(
        .BEAT_BYTES(LANE_BYTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Far beyond the slowest correct run: every event a nine-beat record under heavy stalls.
    initial
    begin
        #4ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            ledger.check_beat(out_data);
    end

    // The receiver switches between stall patterns of random length.
    initial
    begin
        int mode;
        int span;
        int k;
        logic [15:0] mask;
        out_ready <= 1'b0;
        k = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            mask = 16'($urandom) | 16'h0001;
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 9) < 7);
                    2: out_ready <= mask[k % 16];
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                k++;
            end
        end
    end

    function automatic logic [63:0] pick64();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic event_t random_event();
        event_t ev;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            ev.kind = KIND_NEW;
        else if (r < 60)
            ev.kind = KIND_CANCEL;
        else if (r < 92)
            ev.kind = KIND_FILL;
        else
            ev.kind = KIND_NONE;
        ev.sequence_req = pick64();
        ev.timestamp = pick64();
        ev.order_id = pick64();
        ev.second_id = pick64();
        ev.symbol_id = 32'(pick64());
        ev.trader_id = 32'(pick64());
        ev.is_buy = 1'($urandom_range(0, 1));
        ev.price_ticks = pick64();
        ev.quantity = 32'(pick64());
        ev.remaining_quantity = 32'(pick64());
        ev.order_type = 8'(pick64());
        return ev;
    endfunction

    // Leaves in_valid high so that the next event can follow in the very next cycle.
    task automatic send_event(input event_t ev);
        in_valid <= 1'b1;
        in_data <= ev;
        do
            @(posedge clk);
        while (!in_ready);
        ledger.frame_event(ev);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        ledger.set_code(idx, val);
    endtask

    // The spare index is written too; the block must ignore it.
    task automatic program_codes(input logic [7:0] c_new, input logic [7:0] c_cancel,
                                 input logic [7:0] c_fill);
        write_reg(CFG_NEW_ORDER, c_new);
        write_reg(CFG_SPARE, 8'($urandom));
        write_reg(CFG_CANCEL, c_cancel);
        write_reg(CFG_FILL, c_fill);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_bursts(input int count);
        int sent;
        int burst;
        int gap;
        event_t ev;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            for (int b = 0; b < burst && sent < count; b++)
            begin
                ev = random_event();
                send_event(ev);
                sent++;
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic run_directed();
        event_t ev;
        logic [KIND_W-1:0] kinds [3];
        kinds[0] = KIND_NEW;
        kinds[1] = KIND_CANCEL;
        kinds[2] = KIND_FILL;
        foreach (kinds[i])
        begin
            ev = '0;
            ev.kind = kinds[i];
            send_event(ev);
            ev = '1;
            ev.kind = kinds[i];
            send_event(ev);
        end
        ev = random_event();
        ev.kind = KIND_NEW;
        ev.is_buy = 1'b1;
        ev.price_ticks = 64'h8000_0000_0000_0000;
        send_event(ev);
        ev = random_event();
        ev.kind = KIND_FILL;
        ev.is_buy = 1'b0;
        ev.price_ticks = 64'h7FFF_FFFF_FFFF_FFFF;
        send_event(ev);
        // Cancel with junk in every field it does not use.
        ev = '1;
        ev.kind = KIND_CANCEL;
        ev.timestamp = {$urandom, $urandom};
        send_event(ev);
        ev = '1;
        send_event(ev);
        ev = '0;
        ev.kind = KIND_NONE;
        send_event(ev);
        ev = random_event();
        ev.kind = KIND_FILL;
        send_event(ev);
        settle();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_NEW_ORDER;
        cfg_data <= 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: program_codes(8'h00, 8'h00, 8'h00);
                1: program_codes(8'hFF, 8'hFF, 8'hFF);
                3: program_codes(8'd0, 8'd1, 8'd2);
                default: program_codes(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            if (phase == 2)
            begin
                // Let the output run dry in the middle of a phase.
                send_bursts(PHASE_EVENTS / 2);
                settle();
                send_bursts(PHASE_EVENTS - PHASE_EVENTS / 2);
            end
            else
            begin
                send_bursts(PHASE_EVENTS);
            end
            settle();
        end

        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
